>>> rtl/core/lgs_pkg.sv
// Shared types, codes and default sizes of the toroidal Life generation stepper.
package lgs_pkg;

    localparam int ROW_W          = 64;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int HIST_DEPTH_DEF = 8;

    localparam int DIM_W  = 7;
    localparam int GEN_W  = 16;
    localparam int OROW_W = 6;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [1:0] CFG_MAX_GEN   = 2'd2;

    typedef enum logic [1:0] {
        END_NONE    = 2'd0,
        END_STABLE  = 2'd1,
        END_MAXGEN  = 2'd2,
        END_EXTINCT = 2'd3
    } ending_t;

endpackage

>>> rtl/core/lgs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/lgs_rule.sv
// B3/S23 rule applied to one row from a three-row window with toroidal column wrap.
module lgs_rule
    import lgs_pkg::*;
(
    input  logic [ROW_W-1:0] up_row,
    input  logic [ROW_W-1:0] mid_row,
    input  logic [ROW_W-1:0] dn_row,
    input  logic [DIM_W-1:0] cols_used,
    input  logic [ROW_W-1:0] col_mask,
    output logic [ROW_W-1:0] next_row
);

    localparam int CI_W = $clog2(ROW_W);

    logic [CI_W-1:0]  cm1;
    logic [ROW_W-1:0] ul, ur, ml, mr, dl, dr;
    logic [ROW_W-1:0] nxt;

    assign cm1 = CI_W'(cols_used - DIM_W'(1));

    function automatic logic [ROW_W-1:0] rot_l(input logic [ROW_W-1:0] x,
                                               input logic [CI_W-1:0] top);
        return {x[ROW_W-2:0], x[top]};
    endfunction

    function automatic logic [ROW_W-1:0] rot_r(input logic [ROW_W-1:0] x,
                                               input logic [CI_W-1:0] top);
        return (x >> 1) | (ROW_W'(x[0]) << top);
    endfunction

    assign ul = rot_l(up_row, cm1);
    assign ur = rot_r(up_row, cm1);
    assign ml = rot_l(mid_row, cm1);
    assign mr = rot_r(mid_row, cm1);
    assign dl = rot_l(dn_row, cm1);
    assign dr = rot_r(dn_row, cm1);

    always_comb begin
        logic [3:0] n;
        nxt = '0;
        for (int j = 0; j < ROW_W; j++) begin
            n = 4'(ul[j]) + 4'(up_row[j]) + 4'(ur[j]) + 4'(ml[j]) + 4'(mr[j])
              + 4'(dl[j]) + 4'(dn_row[j]) + 4'(dr[j]);
            nxt[j] = (n == 4'd3) || (mid_row[j] && (n == 4'd2));
        end
    end

    assign next_row = nxt & col_mask;

endmodule

>>> rtl/core/life_toroidal_generation_step.sv
// Top level of the toroidal Life generation stepper: configuration, sequencer and memories.
//
//  channel | direction | handshake              | contents
//  s_      | in        | s_tvalid / s_tready    | tuser cmd; tdata row_index, row_bits
//  m_      | out       | m_tvalid / m_tready    | tuser stopped, ending; tdata row, bits, gen
//  cfg_    | in        | cfg_we                 | cfg_addr register index, cfg_wdata value
//
// A load writes its row in the idle state. An advance emits the R used rows, each read and
// then output while the output register is free; then it compares every one of the MAX_ROWS
// rows against the history memory, one entry a cycle, writes it there and sets the ending,
// then computes the next generation row by row. An advance after a stop emits the end result.
// Reset is synchronous; the memories are not cleared.
// A stalled output holds the sequencer; a new item is taken only while it is idle.
module life_toroidal_generation_step
    import lgs_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [0:0]       s_tuser,   // [0] cmd
    input  logic [71:0]      s_tdata,   // [5:0] row_index, [69:6] row_bits
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [2:0]       m_tuser,   // [0] stopped, [2:1] ending
    output logic [87:0]      m_tdata,   // [5:0] out_row, [69:6] out_bits, [85:70] generation
    output logic             m_tlast,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [GEN_W-1:0] cfg_wdata
);

    localparam int RA   = $clog2(MAX_ROWS);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int HW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int KW   = $clog2(HIST_DEPTH + 1);
    localparam int GDEP = 2 ** RA;
    localparam int HDEP = 2 ** (HW + RA);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_END    = 13'b0000000000010,
        ST_E_RD   = 13'b0000000000100,
        ST_E_OUT  = 13'b0000000001000,
        ST_C_RD   = 13'b0000000010000,
        ST_C_LD   = 13'b0000000100000,
        ST_C_HIST = 13'b0000001000000,
        ST_C_FIN  = 13'b0000010000000,
        ST_N_RDL  = 13'b0000100000000,
        ST_N_RD0  = 13'b0001000000000,
        ST_N_LD0  = 13'b0010000000000,
        ST_N_RD   = 13'b0100000000000,
        ST_N_CALC = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0] grid_rows_reg, grid_cols_reg;
    logic [GEN_W-1:0] max_gen_reg;

    logic [RCW-1:0]        rc_reg, rc_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [HW-1:0]         hist_next_reg, hist_next_next;
    logic [KW-1:0]         hist_cnt_reg, hist_cnt_next;
    logic [GEN_W-1:0]      gen_reg, gen_next;
    logic                  stopped_reg, stopped_next;
    ending_t               ending_reg, ending_next;
    logic [HIST_DEPTH-1:0] match_reg, match_next;
    logic                  dead_reg, dead_next;
    logic [ROW_W-1:0]      cur_reg, cur_next;
    logic [ROW_W-1:0]      up_reg, up_next;
    logic [ROW_W-1:0]      mid_reg, mid_next;
    logic [ROW_W-1:0]      first_reg, first_next;

    logic              m_valid_reg, m_valid_next;
    logic [OROW_W-1:0] m_row_reg, m_row_next;
    logic [ROW_W-1:0]  m_bits_reg, m_bits_next;
    logic [GEN_W-1:0]  m_gen_reg, m_gen_next;
    logic              m_stop_reg, m_stop_next;
    ending_t           m_end_reg, m_end_next;
    logic              m_last_reg, m_last_next;

    logic [RCW-1:0]   rows_used;
    logic [DIM_W-1:0] cols_used;
    logic [ROW_W-1:0] col_mask;
    logic [RCW-1:0]   rc_inc;
    logic             out_free;
    logic             in_accept;

    logic             g_we, g_re;
    logic [RA-1:0]    g_waddr, g_raddr;
    logic [ROW_W-1:0] g_wdata, g_rdata, g_masked;
    logic             h_we, h_re;
    logic [HW+RA-1:0] h_waddr, h_raddr;
    logic [ROW_W-1:0] h_rdata;
    logic [ROW_W-1:0] dn_row, rule_row;

    always_comb begin
        if (grid_rows_reg < DIM_W'(3)) begin
            rows_used = RCW'(3);
        end else if (32'(grid_rows_reg) > MAX_ROWS) begin
            rows_used = RCW'(MAX_ROWS);
        end else begin
            rows_used = RCW'(grid_rows_reg);
        end
        if (grid_cols_reg < DIM_W'(3)) begin
            cols_used = DIM_W'(3);
        end else if (32'(grid_cols_reg) > MAX_COLS) begin
            cols_used = DIM_W'(MAX_COLS);
        end else begin
            cols_used = grid_cols_reg;
        end
    end

    assign col_mask  = (cols_used >= DIM_W'(ROW_W)) ? '1
                     : ((ROW_W'(1) << cols_used) - ROW_W'(1));
    assign rc_inc    = rc_reg + RCW'(1);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign g_masked  = g_rdata & col_mask;
    assign dn_row    = (rc_inc == rows_used) ? first_reg : g_masked;

    lgs_ram #(.WIDTH(ROW_W), .DEPTH(GDEP)) u_grid_ram (
        .aclk    (aclk),
        .wr_en   (g_we),
        .wr_addr (g_waddr),
        .wr_data (g_wdata),
        .rd_en   (g_re),
        .rd_addr (g_raddr),
        .rd_data (g_rdata)
    );

    lgs_ram #(.WIDTH(ROW_W), .DEPTH(HDEP)) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (h_we),
        .wr_addr (h_waddr),
        .wr_data (cur_reg),
        .rd_en   (h_re),
        .rd_addr (h_raddr),
        .rd_data (h_rdata)
    );

    lgs_rule u_rule (
        .up_row    (up_reg),
        .mid_row   (mid_reg),
        .dn_row    (dn_row),
        .cols_used (cols_used),
        .col_mask  (col_mask),
        .next_row  (rule_row)
    );

    always_comb begin
        logic [HIST_DEPTH-1:0] live;
        logic                  hit;
        state_next     = state_reg;
        rc_next        = rc_reg;
        k_next         = k_reg;
        hist_next_next = hist_next_reg;
        hist_cnt_next  = hist_cnt_reg;
        gen_next       = gen_reg;
        stopped_next   = stopped_reg;
        ending_next    = ending_reg;
        match_next     = match_reg;
        dead_next      = dead_reg;
        cur_next       = cur_reg;
        up_next        = up_reg;
        mid_next       = mid_reg;
        first_next     = first_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_row_next     = m_row_reg;
        m_bits_next    = m_bits_reg;
        m_gen_next     = m_gen_reg;
        m_stop_next    = m_stop_reg;
        m_end_next     = m_end_reg;
        m_last_next    = m_last_reg;
        g_we           = 1'b0;
        g_waddr        = RA'(s_tdata[5:0]);
        g_wdata        = s_tdata[69:6];
        g_re           = 1'b0;
        g_raddr        = rc_reg[RA-1:0];
        h_we           = 1'b0;
        h_waddr        = {hist_next_reg, rc_reg[RA-1:0]};
        h_re           = 1'b0;
        h_raddr        = {HW'(k_reg), rc_reg[RA-1:0]};
        live           = '0;
        hit            = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser[0] == CMD_LOAD) begin
                        g_we = (32'(s_tdata[5:0]) < MAX_ROWS);
                    end else if (stopped_reg) begin
                        state_next = ST_END;
                    end else begin
                        rc_next    = '0;
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = '0;
                    m_bits_next  = '0;
                    m_gen_next   = gen_reg;
                    m_stop_next  = 1'b1;
                    m_end_next   = ending_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_E_RD: begin
                g_re       = 1'b1;
                state_next = ST_E_OUT;
            end
            ST_E_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = OROW_W'(rc_reg);
                    m_bits_next  = g_masked;
                    m_gen_next   = gen_reg;
                    m_stop_next  = 1'b0;
                    m_end_next   = END_NONE;
                    m_last_next  = (rc_inc == rows_used);
                    if (rc_inc == rows_used) begin
                        gen_next   = gen_reg + GEN_W'(1);
                        rc_next    = '0;
                        match_next = '1;
                        dead_next  = 1'b1;
                        state_next = ST_C_RD;
                    end else begin
                        rc_next    = rc_inc;
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_C_RD: begin
                g_re       = (rc_reg < rows_used);
                state_next = ST_C_LD;
            end
            ST_C_LD: begin
                cur_next   = (rc_reg < rows_used) ? g_masked : '0;
                dead_next  = dead_reg && (cur_next == '0);
                k_next     = '0;
                state_next = ST_C_HIST;
            end
            ST_C_HIST: begin
                if (k_reg != '0 && h_rdata != cur_reg) begin
                    match_next[HW'(k_reg - KW'(1))] = 1'b0;
                end
                if (32'(k_reg) < HIST_DEPTH) begin
                    h_re   = 1'b1;
                    k_next = k_reg + KW'(1);
                end else begin
                    h_we = 1'b1;
                    if (rc_reg == RCW'(MAX_ROWS - 1)) begin
                        state_next = ST_C_FIN;
                    end else begin
                        rc_next    = rc_inc;
                        state_next = ST_C_RD;
                    end
                end
            end
            ST_C_FIN: begin
                for (int k = 0; k < HIST_DEPTH; k++) begin
                    live[k] = (KW'(k) < hist_cnt_reg);
                end
                hit = |(match_reg & live);
                if (hit) begin
                    stopped_next = 1'b1;
                    ending_next  = END_STABLE;
                end
                if (gen_reg == max_gen_reg) begin
                    stopped_next = 1'b1;
                    ending_next  = END_MAXGEN;
                end
                if (dead_reg) begin
                    stopped_next = 1'b1;
                    ending_next  = END_EXTINCT;
                end
                hist_next_next = (32'(hist_next_reg) == HIST_DEPTH - 1) ? '0
                               : hist_next_reg + HW'(1);
                if (32'(hist_cnt_reg) < HIST_DEPTH) begin
                    hist_cnt_next = hist_cnt_reg + KW'(1);
                end
                state_next = ST_N_RDL;
            end
            ST_N_RDL: begin
                g_re       = 1'b1;
                g_raddr    = RA'(rows_used - RCW'(1));
                state_next = ST_N_RD0;
            end
            ST_N_RD0: begin
                up_next    = g_masked;
                g_re       = 1'b1;
                g_raddr    = '0;
                state_next = ST_N_LD0;
            end
            ST_N_LD0: begin
                mid_next   = g_masked;
                first_next = g_masked;
                rc_next    = '0;
                state_next = ST_N_RD;
            end
            ST_N_RD: begin
                g_re       = (rc_inc != rows_used);
                g_raddr    = RA'(rc_inc);
                state_next = ST_N_CALC;
            end
            ST_N_CALC: begin
                g_we     = 1'b1;
                g_waddr  = rc_reg[RA-1:0];
                g_wdata  = rule_row;
                up_next  = mid_reg;
                mid_next = dn_row;
                if (rc_inc == rows_used) begin
                    state_next = ST_IDLE;
                end else begin
                    rc_next    = rc_inc;
                    state_next = ST_N_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            grid_rows_reg <= DIM_W'(64);
            grid_cols_reg <= DIM_W'(64);
            max_gen_reg   <= GEN_W'(10);
            rc_reg        <= '0;
            k_reg         <= '0;
            hist_next_reg <= '0;
            hist_cnt_reg  <= '0;
            gen_reg       <= GEN_W'(1);
            stopped_reg   <= 1'b0;
            ending_reg    <= END_NONE;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rc_reg        <= rc_next;
            k_reg         <= k_next;
            hist_next_reg <= hist_next_next;
            hist_cnt_reg  <= hist_cnt_next;
            gen_reg       <= gen_next;
            stopped_reg   <= stopped_next;
            ending_reg    <= ending_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_GRID_ROWS: grid_rows_reg <= cfg_wdata[DIM_W-1:0];
                    CFG_GRID_COLS: grid_cols_reg <= cfg_wdata[DIM_W-1:0];
                    CFG_MAX_GEN:   max_gen_reg   <= cfg_wdata;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        match_reg  <= match_next;
        dead_reg   <= dead_next;
        cur_reg    <= cur_next;
        up_reg     <= up_next;
        mid_reg    <= mid_next;
        first_reg  <= first_next;
        m_row_reg  <= m_row_next;
        m_bits_reg <= m_bits_next;
        m_gen_reg  <= m_gen_next;
        m_stop_reg <= m_stop_next;
        m_end_reg  <= m_end_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_end_reg, m_stop_reg};
    assign m_tdata  = {2'b00, m_gen_reg, m_bits_reg, m_row_reg};

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared without reset");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stop_reg) |-> (m_last_reg && m_end_reg != END_NONE))
        else $error("end result without last or ending code");

    a_hist_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(hist_cnt_reg) <= HIST_DEPTH) && (32'(hist_next_reg) < HIST_DEPTH))
        else $error("history pointers out of range");

    a_no_grid_write_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_C_HIST || state_reg == ST_C_LD || state_reg == ST_C_RD) |-> !g_we)
        else $error("grid written during history compare");

endmodule
